### design/nsr_pkg.sv
// Shared types and fixed-point constants for the normal strength renormalize unit.
// No dependencies; imported by every module of the block.
package nsr_pkg;

    localparam int STRENGTH_W    = 16;
    localparam int STRENGTH_FRAC = 12;
    localparam int WORK_FRAC     = 26;
    // Scaled tangent magnitudes never exceed 2^29 in the Q.26 working format.
    localparam int MAG_W         = 30;
    localparam int SUM_W         = 60;
    localparam int ROOT_W        = 30;

    localparam logic signed [STRENGTH_W-1:0] STRENGTH_RESET = 16'sd4096;

    typedef struct packed {
        logic             neg_u;
        logic             neg_v;
        logic [MAG_W-1:0] mag_u;
        logic [MAG_W-1:0] mag_v;
    } tangent_side_t;

endpackage

### design/nsr_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on nsr_pkg for widths and the tangent side-band struct.
module nsr_isqrt
    import nsr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [SUM_W-1:0]    in_sum,
    input  tangent_side_t       in_side,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   out_root,
    output tangent_side_t       out_side
);

    localparam int STEPS = ROOT_W;
    localparam int REM_W = ROOT_W + 1;

    logic [STEPS:0]      valid_reg;
    logic [SUM_W-1:0]    sum_reg  [STEPS];
    logic [REM_W-1:0]    rem_reg  [STEPS+1];
    logic [ROOT_W-1:0]   root_reg [STEPS+1];
    tangent_side_t       side_reg [STEPS+1];
    logic [REM_W-1:0]    rem_next  [STEPS];
    logic [ROOT_W-1:0]   root_next [STEPS];

    // Each stage brings down the next two radicand bits and tries root*4+1.
    always_comb
    begin
        logic [REM_W+1:0] shifted;
        logic [REM_W+1:0] trial;
        shifted = '0;
        trial   = '0;
        for (int i = 0; i < STEPS; i++)
        begin
            shifted = {rem_reg[i], sum_reg[i][SUM_W-1-2*i -: 2]};
            trial   = {1'b0, root_reg[i], 2'b01};
            if (shifted >= trial)
            begin
                rem_next[i]  = REM_W'(shifted - trial);
                root_next[i] = {root_reg[i][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = shifted[REM_W-1:0];
                root_next[i] = {root_reg[i][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg[0]  <= in_sum;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        side_reg[0] <= in_side;
        for (int i = 0; i < STEPS - 1; i++)
        begin
            sum_reg[i+1] <= sum_reg[i];
        end
        for (int i = 0; i < STEPS; i++)
        begin
            rem_reg[i+1]  <= rem_next[i];
            root_reg[i+1] <= root_next[i];
            side_reg[i+1] <= side_reg[i];
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign out_root  = root_reg[STEPS];
    assign out_side  = side_reg[STEPS];

endmodule

### design/nsr_recip.sv
// Pipelined rounded reciprocal: round(2^(QUOT_W+WORK_FRAC-1) / root), one quotient bit a stage.
// Depends on nsr_pkg for widths and the tangent side-band struct.
module nsr_recip
    import nsr_pkg::*;
#(
    parameter int QUOT_W = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [ROOT_W-1:0]   in_root,
    input  tangent_side_t       in_side,
    output logic                out_valid,
    output logic [QUOT_W-1:0]   out_quot,
    output tangent_side_t       out_side
);

    localparam int STEPS = QUOT_W;
    localparam int EXT_W = ROOT_W + QUOT_W;

    logic [STEPS:0]      valid_reg;
    logic [ROOT_W-1:0]   div_reg  [STEPS+1];
    logic [ROOT_W-1:0]   rem_reg  [STEPS+1];
    logic [QUOT_W-1:0]   low_reg  [STEPS+1];
    logic [QUOT_W-1:0]   quot_reg [STEPS+1];
    tangent_side_t       side_reg [STEPS+1];
    logic [ROOT_W-1:0]   rem_next  [STEPS];
    logic [QUOT_W-1:0]   quot_next [STEPS];
    logic [EXT_W-1:0]    half_ext;
    logic [ROOT_W-1:0]   rem_first;

    // The dividend is 2^(QUOT_W+25) plus half the root for rounding. Its leading part
    // is already below the root, so only QUOT_W quotient bits remain to be found.
    always_comb
    begin
        half_ext  = EXT_W'(in_root >> 1);
        rem_first = ROOT_W'(half_ext >> QUOT_W) | (ROOT_W'(1) << (WORK_FRAC - 1));
    end

    always_comb
    begin
        logic [ROOT_W:0] shifted;
        logic            take;
        shifted = '0;
        take    = 1'b0;
        for (int i = 0; i < STEPS; i++)
        begin
            shifted = {rem_reg[i], low_reg[i][QUOT_W-1-i]};
            take    = (shifted >= {1'b0, div_reg[i]});
            if (take)
            begin
                rem_next[i] = ROOT_W'(shifted - {1'b0, div_reg[i]});
            end
            else
            begin
                rem_next[i] = shifted[ROOT_W-1:0];
            end
            quot_next[i] = {quot_reg[i][QUOT_W-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg[0]  <= in_root;
        rem_reg[0]  <= rem_first;
        low_reg[0]  <= half_ext[QUOT_W-1:0];
        quot_reg[0] <= '0;
        side_reg[0] <= in_side;
        for (int i = 0; i < STEPS; i++)
        begin
            div_reg[i+1]  <= div_reg[i];
            rem_reg[i+1]  <= rem_next[i];
            low_reg[i+1]  <= low_reg[i];
            quot_reg[i+1] <= quot_next[i];
            side_reg[i+1] <= side_reg[i];
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign out_quot  = quot_reg[STEPS];
    assign out_side  = side_reg[STEPS];

endmodule

### design/normal_strength_renormalize_unit.sv
// Top level of the normal strength renormalize unit: scaling, squares, root, reciprocal, output.
// Depends on nsr_pkg, nsr_isqrt and nsr_recip.
//
// Usage:
// A request carries the two tangent components of a unit normal (signed Q1.F,
// F = COMPONENT_BITS-1) on tangent_u and tangent_v and is taken at a rising edge
// where start is high and busy is low. Busy never rises: the pipeline takes one
// request in every cycle, back to back, with no gaps needed between requests.
// Both tangents are scaled by the signed Q4.12 strength, the up component is
// found as 1/sqrt(1 + su^2 + sv^2) and the scaled tangents are multiplied by it.
// Each request yields exactly one result on out_up, out_u and out_v, marked by
// done for a single cycle. The results pass through the square root, which resolves
// one root bit a stage over 30 stages, and the reciprocal, which resolves one
// quotient bit a stage over COMPONENT_BITS stages. The receiver cannot hold results
// back, so nothing ever stalls. The strength register is written through cfg_we and
// cfg_wdata; the user must write it only while no request is in flight, and the block
// itself does not enforce this. Reset clears every in-flight request and sets
// strength to 1.0.
module normal_strength_renormalize_unit
    import nsr_pkg::*;
#(
    parameter int COMPONENT_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cfg_we,
    input  logic [STRENGTH_W-1:0]             cfg_wdata,
    input  logic signed [COMPONENT_BITS-1:0]  tangent_u,
    input  logic signed [COMPONENT_BITS-1:0]  tangent_v,
    output logic                              done,
    output logic [COMPONENT_BITS-2:0]         out_up,
    output logic signed [COMPONENT_BITS-1:0]  out_u,
    output logic signed [COMPONENT_BITS-1:0]  out_v
);

    localparam int C        = COMPONENT_BITS;
    localparam int FRAC     = C - 1;
    localparam int UP_W     = C - 1;
    localparam int PROD_W   = C + STRENGTH_W;
    localparam int RSH      = (FRAC + STRENGTH_FRAC > WORK_FRAC) ?
                              (FRAC + STRENGTH_FRAC - WORK_FRAC) : 0;
    localparam int LSH      = (FRAC + STRENGTH_FRAC < WORK_FRAC) ?
                              (WORK_FRAC - FRAC - STRENGTH_FRAC) : 0;
    localparam int EXT_W    = PROD_W + LSH + 1;
    localparam longint unsigned SCALE_BIAS = (RSH > 0) ? (64'd1 << (RSH - 1)) : 64'd0;
    localparam int TAN_W    = MAG_W + UP_W;
    localparam int QT_W     = TAN_W - WORK_FRAC + 1;
    localparam int LATENCY  = C + 38;

    localparam logic [UP_W-1:0]  UP_MAX   = {UP_W{1'b1}};
    localparam logic [C-1:0]     QUOT_LIM = C'(1) << FRAC;
    localparam logic [SUM_W-1:0] ONE_SQ   = SUM_W'(1) << (2 * WORK_FRAC);

    // Strength register
    logic signed [STRENGTH_W-1:0] strength_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= STRENGTH_RESET;
        end
        else if (cfg_we)
        begin
            strength_reg <= $signed(cfg_wdata);
        end
    end

    assign busy = 1'b0;

    // Stage A: magnitudes and result signs
    logic                  a_valid_reg;
    logic [C-1:0]          a_tm_u_reg;
    logic [C-1:0]          a_tm_v_reg;
    logic [STRENGTH_W-1:0] a_sm_reg;
    logic                  a_neg_u_reg;
    logic                  a_neg_v_reg;
    logic [C-1:0]          a_tm_u_next;
    logic [C-1:0]          a_tm_v_next;
    logic [STRENGTH_W-1:0] a_sm_next;

    always_comb
    begin
        a_tm_u_next = tangent_u[C-1] ? $unsigned(-tangent_u) : $unsigned(tangent_u);
        a_tm_v_next = tangent_v[C-1] ? $unsigned(-tangent_v) : $unsigned(tangent_v);
        a_sm_next   = strength_reg[STRENGTH_W-1] ? $unsigned(-strength_reg)
                                                 : $unsigned(strength_reg);
    end

    // Stage B: tangent times strength
    logic                  b_valid_reg;
    logic [PROD_W-1:0]     b_prod_u_reg;
    logic [PROD_W-1:0]     b_prod_v_reg;
    logic                  b_neg_u_reg;
    logic                  b_neg_v_reg;

    // Stage C: rounded to the Q.26 working format
    logic                  c_valid_reg;
    tangent_side_t         c_side_reg;
    tangent_side_t         c_side_next;

    function automatic logic [MAG_W-1:0] to_work(input logic [PROD_W-1:0] prod);
        logic [EXT_W-1:0] biased;
        biased = EXT_W'(prod) + EXT_W'(SCALE_BIAS);
        return MAG_W'((biased >> RSH) << LSH);
    endfunction

    always_comb
    begin
        c_side_next.neg_u = b_neg_u_reg;
        c_side_next.neg_v = b_neg_v_reg;
        c_side_next.mag_u = to_work(b_prod_u_reg);
        c_side_next.mag_v = to_work(b_prod_v_reg);
    end

    // Stage D: squares of the scaled tangents
    logic                  d_valid_reg;
    logic [SUM_W-1:0]      d_sq_u_reg;
    logic [SUM_W-1:0]      d_sq_v_reg;
    tangent_side_t         d_side_reg;
    logic [SUM_W-1:0]      sum_sq;

    assign sum_sq = ONE_SQ + d_sq_u_reg + d_sq_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start && !busy;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_tm_u_reg   <= a_tm_u_next;
        a_tm_v_reg   <= a_tm_v_next;
        a_sm_reg     <= a_sm_next;
        a_neg_u_reg  <= tangent_u[C-1] ^ strength_reg[STRENGTH_W-1];
        a_neg_v_reg  <= tangent_v[C-1] ^ strength_reg[STRENGTH_W-1];
        b_prod_u_reg <= PROD_W'(a_tm_u_reg) * PROD_W'(a_sm_reg);
        b_prod_v_reg <= PROD_W'(a_tm_v_reg) * PROD_W'(a_sm_reg);
        b_neg_u_reg  <= a_neg_u_reg;
        b_neg_v_reg  <= a_neg_v_reg;
        c_side_reg   <= c_side_next;
        d_sq_u_reg   <= SUM_W'(c_side_reg.mag_u) * SUM_W'(c_side_reg.mag_u);
        d_sq_v_reg   <= SUM_W'(c_side_reg.mag_v) * SUM_W'(c_side_reg.mag_v);
        d_side_reg   <= c_side_reg;
    end

    // Square root and reciprocal
    logic                root_valid;
    logic [ROOT_W-1:0]   root;
    tangent_side_t       root_side;
    logic                quot_valid;
    logic [C-1:0]        quot;
    tangent_side_t       quot_side;

    nsr_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid_reg),
        .in_sum    (sum_sq),
        .in_side   (d_side_reg),
        .out_valid (root_valid),
        .out_root  (root),
        .out_side  (root_side)
    );

    nsr_recip #(
        .QUOT_W (C)
    ) u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (root_valid),
        .in_root   (root),
        .in_side   (root_side),
        .out_valid (quot_valid),
        .out_quot  (quot),
        .out_side  (quot_side)
    );

    // Stage T0: saturated up component
    logic                t0_valid_reg;
    logic [UP_W-1:0]     t0_up_reg;
    logic                t0_flat_reg;
    tangent_side_t       t0_side_reg;

    // Stage T1: scaled tangents times up
    logic                t1_valid_reg;
    logic [UP_W-1:0]     t1_up_reg;
    logic                t1_flat_reg;
    logic                t1_neg_u_reg;
    logic                t1_neg_v_reg;
    logic [TAN_W-1:0]    t1_prod_u_reg;
    logic [TAN_W-1:0]    t1_prod_v_reg;

    // Stage T2: result registers
    logic                done_reg;
    logic [UP_W-1:0]     out_up_reg;
    logic [C-1:0]        out_u_reg;
    logic [C-1:0]        out_v_reg;

    // Round half up, saturate to the signed range and apply the sign; a flat result is zero.
    function automatic logic [C-1:0] finish_tangent(input logic [TAN_W-1:0] prod,
                                                    input logic neg,
                                                    input logic flat);
        logic [TAN_W:0]  rounded;
        logic [QT_W-1:0] qt;
        logic [C-1:0]    sat;
        rounded = {1'b0, prod} + ((TAN_W + 1)'(1) << (WORK_FRAC - 1));
        qt      = rounded[TAN_W:WORK_FRAC];
        if (neg)
        begin
            sat = (qt > QT_W'(QUOT_LIM)) ? QUOT_LIM : qt[C-1:0];
        end
        else
        begin
            sat = (qt > QT_W'(UP_MAX)) ? C'(UP_MAX) : qt[C-1:0];
        end
        if (flat)
        begin
            return '0;
        end
        return neg ? (~sat + 1'b1) : sat;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_valid_reg <= 1'b0;
            t1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            t0_valid_reg <= quot_valid;
            t1_valid_reg <= t0_valid_reg;
            done_reg     <= t1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t0_up_reg     <= (quot > C'(UP_MAX)) ? UP_MAX : quot[UP_W-1:0];
        t0_flat_reg   <= (quot == '0);
        t0_side_reg   <= quot_side;
        t1_up_reg     <= t0_up_reg;
        t1_flat_reg   <= t0_flat_reg;
        t1_neg_u_reg  <= t0_side_reg.neg_u;
        t1_neg_v_reg  <= t0_side_reg.neg_v;
        t1_prod_u_reg <= TAN_W'(t0_side_reg.mag_u) * TAN_W'(t0_up_reg);
        t1_prod_v_reg <= TAN_W'(t0_side_reg.mag_v) * TAN_W'(t0_up_reg);
        out_up_reg    <= t1_flat_reg ? UP_MAX : t1_up_reg;
        out_u_reg     <= finish_tangent(t1_prod_u_reg, t1_neg_u_reg, t1_flat_reg);
        out_v_reg     <= finish_tangent(t1_prod_v_reg, t1_neg_v_reg, t1_flat_reg);
    end

    assign done   = done_reg;
    assign out_up = out_up_reg;
    assign out_u  = $signed(out_u_reg);
    assign out_v  = $signed(out_v_reg);

    // Every request that entered the first stage comes out with done raised.
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> ##LATENCY done)
        else $error("request lost in the pipeline");

    // The radicand lies in [2^52, 2^60), so the root has its top bits in [26, 29].
    assert property (@(posedge clk) disable iff (!rst_n)
        root_valid |-> root[ROOT_W-1:WORK_FRAC] != '0)
        else $error("square root out of range");

    // The rounded reciprocal of a root of at least 1.0 never exceeds 1.0.
    assert property (@(posedge clk) disable iff (!rst_n)
        quot_valid |-> quot <= QUOT_LIM)
        else $error("reciprocal above one");

    // With the root below 16.0 the up component never reaches zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_up != '0)
        else $error("up component is zero");

endmodule

### tb/normal_strength_renormalize_unit_test.sv
// Self-checking testbench for normal_strength_renormalize_unit: directed and random requests
// under several strengths, checked against a fixed-point predictor held in a scoreboard class.
// Depends on nsr_pkg and the unit itself.
module normal_strength_renormalize_unit_test;
    import nsr_pkg::*;

    localparam int CB      = 16;
    localparam int FRAC    = CB - 1;
    localparam int LATENCY = CB + 38;

    localparam logic signed [CB-1:0] T_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] T_MIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic signed [STRENGTH_W-1:0] STRENGTH_MAX = {1'b0, {(STRENGTH_W-1){1'b1}}};
    localparam logic signed [STRENGTH_W-1:0] STRENGTH_MIN = {1'b1, {(STRENGTH_W-1){1'b0}}};

    class normal_scoreboard;
        typedef struct {
            logic [CB-2:0]          up;
            logic signed [CB-1:0]   u;
            logic signed [CB-1:0]   v;
            logic signed [CB-1:0]   in_u;
            logic signed [CB-1:0]   in_v;
        } expected_normal_t;

        logic signed [STRENGTH_W-1:0] strength;
        expected_normal_t             pending_normals[$];
        int unsigned                  errors;

        function new();
            strength = STRENGTH_RESET;
            errors   = 0;
        endfunction

        function void set_strength(input logic signed [STRENGTH_W-1:0] s);
            strength = s;
        endfunction

        function int pending_count();
            return pending_normals.size();
        endfunction

        function logic [63:0] floor_root(input logic [63:0] x);
            logic [63:0] root;
            logic [63:0] trial;
            root = '0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= x)
                    root = trial;
            end
            return root;
        endfunction

        // Magnitude of t*strength in the Q.26 working format, rounded half away from zero.
        function logic [63:0] scaled_magnitude(input logic signed [CB-1:0] t, output bit neg);
            longint      tl;
            longint      sl;
            logic [63:0] tm;
            logic [63:0] sm;
            logic [63:0] p;
            int          sh;
            sh = FRAC + STRENGTH_FRAC - WORK_FRAC;
            tl = t;
            sl = strength;
            tm = (tl < 0) ? -tl : tl;
            sm = (sl < 0) ? -sl : sl;
            p  = tm * sm;
            neg = ((tl < 0) != (sl < 0)) && (p != 0);
            if (sh > 0)
                return (p + (64'd1 << (sh - 1))) >> sh;
            else if (sh < 0)
                return p << (-sh);
            return p;
        endfunction

        function logic [CB-1:0] renormalised_tangent(input logic [63:0] mag, input bit neg,
                                                     input logic [63:0] up);
            logic [63:0] q;
            logic [63:0] lim;
            q   = (mag * up + (64'd1 << (WORK_FRAC - 1))) >> WORK_FRAC;
            lim = 64'd1 << FRAC;
            if (neg)
            begin
                if (q > lim)
                    q = lim;
                q = -q;
            end
            else if (q > lim - 1)
                q = lim - 1;
            return q[CB-1:0];
        endfunction

        function expected_normal_t predict_normal(input logic signed [CB-1:0] tu,
                                                  input logic signed [CB-1:0] tv);
            expected_normal_t e;
            bit               nu;
            bit               nv;
            logic [63:0]      su;
            logic [63:0]      sv;
            logic [63:0]      sum;
            logic [63:0]      root;
            logic [63:0]      up;
            logic [63:0]      up_max;
            su     = scaled_magnitude(tu, nu);
            sv     = scaled_magnitude(tv, nv);
            sum    = (64'd1 << (2 * WORK_FRAC)) + su * su + sv * sv;
            root   = floor_root(sum);
            if (root == 0)
                root = 1;
            up     = ((64'd1 << (FRAC + WORK_FRAC)) + (root >> 1)) / root;
            up_max = (64'd1 << FRAC) - 1;
            if (up > up_max)
                up = up_max;
            e.in_u = tu;
            e.in_v = tv;
            // An up component that rounds away to nothing gives the flat normal.
            if (up == 0)
            begin
                e.up = up_max[CB-2:0];
                e.u  = '0;
                e.v  = '0;
            end
            else
            begin
                e.up = up[CB-2:0];
                e.u  = renormalised_tangent(su, nu, up);
                e.v  = renormalised_tangent(sv, nv, up);
            end
            return e;
        endfunction

        function void note_request(input logic signed [CB-1:0] tu, input logic signed [CB-1:0] tv);
            pending_normals = {pending_normals, predict_normal(tu, tv)};
        endfunction

        task report_mismatch(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(input logic [CB-2:0] up, input logic signed [CB-1:0] u,
                          input logic signed [CB-1:0] v);
            expected_normal_t e;
            if (pending_normals.size() == 0)
            begin
                report_mismatch($sformatf("result up=%0d u=%0d v=%0d with no request waiting",
                                          up, u, v));
                return;
            end
            e = pending_normals.pop_front();
            if (up !== e.up)
                report_mismatch($sformatf("out_up %0d, expected %0d (u=%0d v=%0d)",
                                          up, e.up, e.in_u, e.in_v));
            if (u !== e.u)
                report_mismatch($sformatf("out_u %0d, expected %0d (u=%0d v=%0d)",
                                          u, e.u, e.in_u, e.in_v));
            if (v !== e.v)
                report_mismatch($sformatf("out_v %0d, expected %0d (u=%0d v=%0d)",
                                          v, e.v, e.in_u, e.in_v));
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          cfg_we;
    logic [STRENGTH_W-1:0]         cfg_wdata;
    logic signed [CB-1:0]          tangent_u;
    logic signed [CB-1:0]          tangent_v;
    logic                          busy;
    logic                          done;
    logic [CB-2:0]                 out_up;
    logic signed [CB-1:0]          out_u;
    logic signed [CB-1:0]          out_v;

    normal_scoreboard sb = new();
    int unsigned      idle_pct;

    normal_strength_renormalize_unit #(
        .COMPONENT_BITS(CB)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .tangent_u (tangent_u),
        .tangent_v (tangent_v),
        .done      (done),
        .out_up    (out_up),
        .out_u     (out_u),
        .out_v     (out_v)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    // Values are sampled before the edge's own updates, so this sees what the unit saw.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request(tangent_u, tangent_v);
            if (done)
                sb.check_result(out_up, out_u, out_v);
        end
    end

    task automatic send_request(input logic signed [CB-1:0] u, input logic signed [CB-1:0] v);
        start     <= 1'b1;
        tangent_u <= u;
        tangent_v <= v;
        do
            @(posedge clk);
        while (busy);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Start drops and the clock advances before polling, so a request already taken is noted.
    task automatic wait_until_settled();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_strength(input logic signed [STRENGTH_W-1:0] s);
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_strength(s);
    endtask

    function automatic logic signed [CB-1:0] pick_tangent();
        logic [CB-1:0] raw;
        raw = CB'($urandom);
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return T_MAX;
                    1: return T_MIN;
                    2: return '0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            1, 2: return $urandom_range(0, 1) ? CB'($urandom_range(0, 255))
                                              : CB'(-$urandom_range(0, 255));
            default: return raw;
        endcase
    endfunction

    function automatic logic signed [STRENGTH_W-1:0] pick_strength();
        logic [STRENGTH_W-1:0] raw;
        raw = STRENGTH_W'($urandom);
        case ($urandom_range(0, 6))
            0: return STRENGTH_MIN;
            1: return STRENGTH_MAX;
            2: return '0;
            3: return $urandom_range(0, 1) ? STRENGTH_RESET : -STRENGTH_RESET;
            4: return $urandom_range(0, 1) ? STRENGTH_W'($urandom_range(0, 8192))
                                           : STRENGTH_W'(-$urandom_range(0, 8192));
            default: return raw;
        endcase
    endfunction

    initial
    begin
        start     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        tangent_u <= '0;
        tangent_v <= '0;
        rst_n     <= 1'b0;
        idle_pct  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset strength of 1.0 first, then the zero strength, the extremes and -1.0.
        send_request(0, 0);
        send_request(T_MAX, T_MAX);
        send_request(T_MIN, T_MIN);
        send_request(T_MIN, T_MAX);
        send_request(T_MAX, T_MIN);
        send_request(1, -1);
        send_request(-1, 1);
        send_request(23170, -23170);
        wait_until_settled();
        write_strength('0);
        send_request(T_MAX, T_MIN);
        send_request(12345, -321);
        wait_until_settled();
        write_strength(STRENGTH_MIN);
        send_request(T_MIN, T_MIN);
        send_request(T_MAX, 0);
        send_request(0, T_MIN);
        send_request(-1, -1);
        wait_until_settled();
        write_strength(STRENGTH_MAX);
        send_request(T_MAX, T_MAX);
        send_request(T_MIN, 1);
        send_request(2, -2);
        wait_until_settled();
        write_strength(-STRENGTH_RESET);
        send_request(16384, 8192);
        send_request(-5, 7);

        for (int mode = 0; mode < 3; mode++)
        begin
            idle_pct = (mode == 0) ? 21 : (mode == 1) ? 83 : 0;
            for (int blk = 0; blk < 5; blk++)
            begin
                wait_until_settled();
                write_strength(pick_strength());
                for (int n = 0; n < 94; n++)
                begin
                    // Now and then the sender holds off until the pipeline has emptied.
                    if ($urandom_range(0, 99) == 0)
                        wait_until_settled();
                    send_request(pick_tangent(), pick_tangent());
                end
            end
        end

        wait_until_settled();
        repeat (LATENCY + 8) @(posedge clk);
        if (sb.pending_count() != 0)
            sb.report_mismatch($sformatf("%0d requests never answered", sb.pending_count()));
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
design/nsr_pkg.sv
design/nsr_isqrt.sv
design/nsr_recip.sv
design/normal_strength_renormalize_unit.sv
tb/normal_strength_renormalize_unit_test.sv
